>>> src/ocpg_pkg.sv
// Shared types, constants and tables for the oriented circle point generator.
package ocpg_pkg;

  localparam int DIV_NUM_W = 62;
  localparam int DIV_DEN_W = 32;
  localparam int SQRT_IN_W = 60;
  localparam int SQRT_OUT_W = 30;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SQ_X, ST_SQ_Y, ST_SQ_Z, ST_TILT, ST_TILT_CHK, ST_SQRT, ST_UDIV,
    ST_MUL_XX, ST_MUL_YY, ST_MUL_XY, ST_RAT_PREP, ST_RAT, ST_RAT_WAIT, ST_MATRIX,
    ST_PH_DIV, ST_P_ANG, ST_P_Z, ST_P_COR, ST_P_MX, ST_P_MY, ST_P_M0, ST_P_M1,
    ST_P_M2, ST_P_M3, ST_P_M4, ST_P_M5, ST_P_ZS, ST_P_EMIT
  } ocpg_state_t;

  // Q30 arctangent of 2^-k, truncated
  function automatic logic signed [31:0] atan_q30(input logic [4:0] k);
    logic signed [31:0] v;
    case (k)
      5'd0:  v = 32'sh3243F6A8;
      5'd1:  v = 32'sh1DAC6705;
      5'd2:  v = 32'sh0FADBAFC;
      5'd3:  v = 32'sh07F56EA6;
      5'd4:  v = 32'sh03FEAB76;
      5'd5:  v = 32'sh01FFD55B;
      5'd6:  v = 32'sh00FFFAAA;
      5'd7:  v = 32'sh007FFF55;
      5'd8:  v = 32'sh003FFFEA;
      5'd9:  v = 32'sh001FFFFD;
      5'd10: v = 32'sh000FFFFF;
      5'd11: v = 32'sh0007FFFF;
      5'd12: v = 32'sh0003FFFF;
      5'd13: v = 32'sh0001FFFF;
      5'd14: v = 32'sh0000FFFF;
      5'd15: v = 32'sh00007FFF;
      5'd16: v = 32'sh00003FFF;
      5'd17: v = 32'sh00001FFF;
      5'd18: v = 32'sh00000FFF;
      5'd19: v = 32'sh000007FF;
      5'd20: v = 32'sh000003FF;
      5'd21: v = 32'sh000001FF;
      5'd22: v = 32'sh000000FF;
      5'd23: v = 32'sh0000007F;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

>>> src/ocpg_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module ocpg_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [ocpg_pkg::DIV_NUM_W-1:0] num,
  input  logic [ocpg_pkg::DIV_DEN_W-1:0] den,
  output logic                           done,
  output logic [ocpg_pkg::DIV_NUM_W-1:0] quo,
  output logic [ocpg_pkg::DIV_DEN_W-1:0] rem
);
  import ocpg_pkg::*;

  localparam int CNT_W = $clog2(DIV_NUM_W);

  logic                 busy_r, done_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [DIV_NUM_W-1:0] num_r;
  logic [DIV_DEN_W-1:0] rem_r, den_r;
  logic [DIV_DEN_W:0]   trial;
  logic                 fits;

  assign trial = {rem_r, num_r[DIV_NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? DIV_DEN_W'(trial - {1'b0, den_r}) : trial[DIV_DEN_W-1:0];
      num_r <= {num_r[DIV_NUM_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quo  = num_r;
  assign rem  = rem_r;

endmodule

>>> src/ocpg_isqrt.sv
// Digit-by-digit integer square root, two radicand bits per cycle.
module ocpg_isqrt (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [ocpg_pkg::SQRT_IN_W-1:0]  val,
  output logic                            done,
  output logic [ocpg_pkg::SQRT_OUT_W-1:0] root
);
  import ocpg_pkg::*;

  localparam int CNT_W = $clog2(SQRT_OUT_W);

  logic                  busy_r, done_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [SQRT_IN_W-1:0]  val_r;
  logic [SQRT_OUT_W-1:0] root_r;
  logic [32:0]           rem_r, remt, trial;
  logic                  fits;

  assign remt  = {rem_r[30:0], val_r[SQRT_IN_W-1 -: 2]};
  assign trial = {1'b0, root_r, 2'b01};
  assign fits  = remt >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SQRT_OUT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      val_r  <= val;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      val_r  <= {val_r[SQRT_IN_W-3:0], 2'b00};
      rem_r  <= fits ? (remt - trial) : remt;
      root_r <= {root_r[SQRT_OUT_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

>>> src/ocpg_cordic.sv
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, Q30.
module ocpg_cordic #(
  parameter int STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] z_in,
  output logic               done,
  output logic signed [31:0] x_out,
  output logic signed [31:0] y_out
);
  import ocpg_pkg::*;

  localparam int CW = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam logic signed [31:0] X_START = 32'sd652032874;

  logic               busy_r, done_r;
  logic [CW-1:0]      k_r;
  logic signed [31:0] x_r, y_r, z_r, dx, dy, at;

  assign dx = y_r >>> k_r;
  assign dy = x_r >>> k_r;
  assign at = atan_q30(5'(k_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      k_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        k_r    <= '0;
      end else if (busy_r) begin
        k_r <= k_r + 1'b1;
        if (k_r == CW'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      x_r <= X_START;
      y_r <= '0;
      z_r <= z_in;
    end else if (busy_r) begin
      if (!z_r[31]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + at;
      end
    end
  end

  assign done  = done_r;
  assign x_out = x_r;
  assign y_out = y_r;

endmodule

>>> src/oriented_circle_point_generator.sv
// Top level: sequencer, shared multiplier and datapath of the circle generator.
//
// One input item (centre, direction, radius, point count) produces point_count
// output items, the points of a circle of that radius around the centre in the
// plane normal to the direction; the final point carries tlast. The count is
// clamped to MAX_POINTS and a count of zero gives no output. in_tready is high
// only while the block is idle. Per item, setup runs multiplies and compares,
// a square root and six divisions on the shared divider (three for the unit
// vector, three for the rotation ratios, the latter skipped when uz is -1.0)
// plus one division for the angle step; a zero direction or one pointing
// nearly straight up skips the square root and those six divisions. Each point
// then runs the CORDIC loop and nine passes through the single 34x34
// multiplier, and waits to emit while the output register holds an untaken
// point. The output register lets the last point wait while the next item is
// accepted.
module oriented_circle_point_generator #(
  parameter int MAX_POINTS   = 64,
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // centre_x[31:0] centre_y[63:32] centre_z[95:64] dir_x[111:96] dir_y[127:112]
  // dir_z[143:128] circle_radius[174:144] point_count[181:175]
  input  logic [183:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // point_x[31:0] point_y[63:32] point_z[95:64]
  output logic [95:0]  out_tdata,
  output logic         out_tlast
);
  import ocpg_pkg::*;

  localparam logic signed [32:0] ONE_Q30 = 33'sd1073741824;
  localparam logic [31:0]        ANG_SCALE = 32'd1686629713;
  localparam logic [15:0]        TILT_K = 16'd9999;

  // saturate centre + round(sum >> 30)
  function automatic logic signed [31:0] fin(input logic signed [31:0] c,
                                             input logic signed [67:0] s);
    logic signed [67:0] t;
    logic signed [39:0] v;
    t = (s + 68'sd536870912) >>> 30;
    v = {{2{t[37]}}, t[37:0]} + {{8{c[31]}}, c};
    if (v > 40'sd2147483647) return 32'sh7FFFFFFF;
    else if (v < -40'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  ocpg_state_t state_r, state_nxt;

  // captured item
  logic signed [31:0] cen_x_r, cen_y_r, cen_z_r;
  logic signed [15:0] dx_r, dy_r, dz_r;
  logic [30:0]        rad_r;
  logic [6:0]         n_r;

  // shared multiplier
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_p_r;

  // setup
  logic [31:0]        acc_sq_r, s2_r, dz2_r;
  logic [SQRT_OUT_W-1:0] len_r;
  logic [1:0]         comp_r;
  logic signed [31:0] ux_r, uy_r, uz_r;
  logic [60:0]        nxx_r, nyy_r, nxy_r;
  logic               xy_neg_r;
  logic [31:0]        xx_r, yy_r, xy_r;
  logic signed [32:0] c0x_r, c0y_r, c0z_r, c1x_r, c1y_r, c1z_r;

  // point loop
  logic [32:0]        q0_r, phase_r;
  logic [6:0]         r0_r, prem_r, idx_r;
  logic signed [31:0] cs_r, sn_r;
  logic signed [33:0] px_r, py_r;
  logic signed [67:0] acc_r;
  logic signed [31:0] ox_r, oy_r, oz_r;

  // output register
  logic        out_valid_r, out_last_r;
  logic [95:0] out_data_r;

  // units
  logic                 div_start, div_done;
  logic [DIV_NUM_W-1:0] div_num, div_quo;
  logic [DIV_DEN_W-1:0] div_den, div_rem;
  logic                 sq_start, sq_done;
  logic [SQRT_OUT_W-1:0] sq_root;
  logic                 cor_start, cor_done;
  logic signed [31:0]   cor_z, cor_x, cor_y;

  // derived values
  logic [32:0]        len2;
  logic               ident;
  logic signed [15:0] d_sel;
  logic [16:0]        d_mag;
  logic [DIV_NUM_W-1:0] q_unit;
  logic [30:0]        u_mag;
  logic [31:0]        den;
  logic [60:0]        rat_num;
  logic [31:0]        rat_val;
  logic [7:0]         rr;
  logic signed [32:0] xys;
  logic signed [67:0] px_rnd;
  logic [6:0]         n_in;
  logic               emit_ok;

  ocpg_div u_div (
    .clk, .rst_n, .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo), .rem(div_rem)
  );

  // radicand is len2 * 2^28; len2 stays below 2^32
  ocpg_isqrt u_sqrt (
    .clk, .rst_n, .start(sq_start), .val({len2[31:0], 28'd0}),
    .done(sq_done), .root(sq_root)
  );

  ocpg_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk, .rst_n, .start(cor_start), .z_in(cor_z),
    .done(cor_done), .x_out(cor_x), .y_out(cor_y)
  );

  assign len2  = {1'b0, s2_r} + {1'b0, dz2_r};
  assign ident = (len2 == 33'd0) ||
                 (!dz_r[15] && dz_r != 16'sd0 && mul_p_r < $signed({36'd0, dz2_r}));
  assign d_sel = (comp_r == 2'd0) ? dx_r : (comp_r == 2'd1) ? dy_r : dz_r;
  assign d_mag = d_sel[15] ? 17'(-{d_sel[15], d_sel}) : {1'b0, d_sel};
  assign q_unit = div_quo;
  assign u_mag = (q_unit > DIV_NUM_W'(ONE_Q30)) ? 31'h40000000 : q_unit[30:0];
  assign den   = 32'(ONE_Q30 + 33'(uz_r));
  assign rat_num = (comp_r == 2'd0) ? nxx_r : (comp_r == 2'd1) ? nyy_r : nxy_r;
  assign rat_val = (div_quo > DIV_NUM_W'(32'h80000000)) ? 32'h80000000 : div_quo[31:0];
  assign rr    = {1'b0, prem_r} + {1'b0, r0_r};
  assign xys   = xy_neg_r ? -$signed({1'b0, xy_r}) : $signed({1'b0, xy_r});
  assign px_rnd = (mul_p_r + 68'sd536870912) >>> 30;
  assign n_in  = (in_tdata[181:175] > 7'(MAX_POINTS)) ? 7'(MAX_POINTS) : in_tdata[181:175];
  assign emit_ok = !out_valid_r || out_tready;

  assign in_tready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    mul_p_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // sequencer: next state, multiplier operands, unit starts
  always_comb begin
    state_nxt = state_r;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    sq_start  = 1'b0;
    cor_start = 1'b0;
    cor_z     = 32'(mul_p_r >>> 30);
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid && n_in != 7'd0) state_nxt = ST_SQ_X;
      end
      ST_SQ_X: begin
        mul_a = 34'(dx_r); mul_b = 34'(dx_r); state_nxt = ST_SQ_Y;
      end
      ST_SQ_Y: begin
        mul_a = 34'(dy_r); mul_b = 34'(dy_r); state_nxt = ST_SQ_Z;
      end
      ST_SQ_Z: begin
        mul_a = 34'(dz_r); mul_b = 34'(dz_r); state_nxt = ST_TILT;
      end
      ST_TILT: begin
        mul_a = $signed({2'b00, s2_r}); mul_b = $signed({18'd0, TILT_K});
        state_nxt = ST_TILT_CHK;
      end
      ST_TILT_CHK: begin
        if (ident) begin
          div_start = 1'b1;
          div_num   = DIV_NUM_W'(64'd1 << 32);
          div_den   = DIV_DEN_W'(n_r);
          state_nxt = ST_PH_DIV;
        end else begin
          sq_start  = 1'b1;
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (sq_done) begin
          div_start = 1'b1;
          div_num   = DIV_NUM_W'({d_mag, 44'd0});
          div_den   = DIV_DEN_W'(sq_root);
          state_nxt = ST_UDIV;
        end
      end
      ST_UDIV: begin
        if (div_done) begin
          if (comp_r == 2'd2) begin
            state_nxt = ST_MUL_XX;
          end else begin
            div_start = 1'b1;
            div_num   = DIV_NUM_W'({(comp_r == 2'd0) ?
                          (dy_r[15] ? 17'(-{dy_r[15], dy_r}) : {1'b0, dy_r}) :
                          (dz_r[15] ? 17'(-{dz_r[15], dz_r}) : {1'b0, dz_r}), 44'd0});
            div_den   = DIV_DEN_W'(len_r);
          end
        end
      end
      ST_MUL_XX: begin
        mul_a = 34'(ux_r); mul_b = 34'(ux_r); state_nxt = ST_MUL_YY;
      end
      ST_MUL_YY: begin
        mul_a = 34'(uy_r); mul_b = 34'(uy_r); state_nxt = ST_MUL_XY;
      end
      ST_MUL_XY: begin
        mul_a = 34'(ux_r); mul_b = 34'(uy_r); state_nxt = ST_RAT_PREP;
      end
      ST_RAT_PREP: state_nxt = ST_RAT;
      ST_RAT: begin
        if (den == 32'd0) begin
          if (comp_r == 2'd2) state_nxt = ST_MATRIX;
        end else begin
          div_start = 1'b1;
          div_num   = DIV_NUM_W'(rat_num);
          div_den   = den;
          state_nxt = ST_RAT_WAIT;
        end
      end
      ST_RAT_WAIT: begin
        if (div_done) state_nxt = (comp_r == 2'd2) ? ST_MATRIX : ST_RAT;
      end
      ST_MATRIX: begin
        div_start = 1'b1;
        div_num   = DIV_NUM_W'(64'd1 << 32);
        div_den   = DIV_DEN_W'(n_r);
        state_nxt = ST_PH_DIV;
      end
      ST_PH_DIV: begin
        if (div_done) state_nxt = ST_P_ANG;
      end
      ST_P_ANG: begin
        mul_a = $signed({4'd0, phase_r[29:0]}); mul_b = $signed({2'b00, ANG_SCALE});
        state_nxt = ST_P_Z;
      end
      ST_P_Z: begin
        cor_start = 1'b1;
        state_nxt = ST_P_COR;
      end
      ST_P_COR: begin
        if (cor_done) state_nxt = ST_P_MX;
      end
      ST_P_MX: begin
        mul_a = $signed({3'd0, rad_r}); mul_b = 34'(cs_r); state_nxt = ST_P_MY;
      end
      ST_P_MY: begin
        mul_a = $signed({3'd0, rad_r}); mul_b = 34'(sn_r); state_nxt = ST_P_M0;
      end
      ST_P_M0: begin
        mul_a = 34'(c0x_r); mul_b = px_r; state_nxt = ST_P_M1;
      end
      ST_P_M1: begin
        mul_a = 34'(c1x_r); mul_b = py_r; state_nxt = ST_P_M2;
      end
      ST_P_M2: begin
        mul_a = 34'(c0y_r); mul_b = px_r; state_nxt = ST_P_M3;
      end
      ST_P_M3: begin
        mul_a = 34'(c1y_r); mul_b = py_r; state_nxt = ST_P_M4;
      end
      ST_P_M4: begin
        mul_a = 34'(c0z_r); mul_b = px_r; state_nxt = ST_P_M5;
      end
      ST_P_M5: begin
        mul_a = 34'(c1z_r); mul_b = py_r; state_nxt = ST_P_ZS;
      end
      ST_P_ZS: state_nxt = ST_P_EMIT;
      ST_P_EMIT: begin
        if (emit_ok) state_nxt = (idx_r == n_r - 7'd1) ? ST_IDLE : ST_P_ANG;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath registers; a product shows up in mul_p_r one state after it is issued
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cen_x_r <= in_tdata[31:0];
          cen_y_r <= in_tdata[63:32];
          cen_z_r <= in_tdata[95:64];
          dx_r    <= in_tdata[111:96];
          dy_r    <= in_tdata[127:112];
          dz_r    <= in_tdata[143:128];
          rad_r   <= in_tdata[174:144];
          n_r     <= n_in;
        end
        comp_r <= 2'd0;
      end
      ST_SQ_Y: acc_sq_r <= mul_p_r[31:0];
      ST_SQ_Z: s2_r <= acc_sq_r + mul_p_r[31:0];
      ST_TILT: dz2_r <= mul_p_r[31:0];
      ST_TILT_CHK: begin
        c0x_r <= ONE_Q30; c0y_r <= '0; c0z_r <= '0;
        c1x_r <= '0; c1y_r <= ONE_Q30; c1z_r <= '0;
      end
      ST_SQRT: len_r <= sq_root;
      ST_UDIV: begin
        if (div_done) begin
          case (comp_r)
            2'd0: ux_r <= d_sel[15] ? -$signed({1'b0, u_mag}) : $signed({1'b0, u_mag});
            2'd1: uy_r <= d_sel[15] ? -$signed({1'b0, u_mag}) : $signed({1'b0, u_mag});
            default: uz_r <= d_sel[15] ? -$signed({1'b0, u_mag}) : $signed({1'b0, u_mag});
          endcase
          comp_r <= (comp_r == 2'd2) ? 2'd0 : comp_r + 2'd1;
        end
      end
      ST_MUL_YY: nxx_r <= mul_p_r[60:0];
      ST_MUL_XY: nyy_r <= mul_p_r[60:0];
      ST_RAT_PREP: begin
        nxy_r    <= mul_p_r[67] ? 61'(-mul_p_r) : mul_p_r[60:0];
        xy_neg_r <= ux_r[31] != uy_r[31];
      end
      ST_RAT, ST_RAT_WAIT: begin
        if ((state_r == ST_RAT && den == 32'd0) || (state_r == ST_RAT_WAIT && div_done)) begin
          case (comp_r)
            2'd0: xx_r <= (state_r == ST_RAT) ? ((rat_num != 61'd0) ? 32'h80000000 : 32'd0)
                                              : rat_val;
            2'd1: yy_r <= (state_r == ST_RAT) ? ((rat_num != 61'd0) ? 32'h80000000 : 32'd0)
                                              : rat_val;
            default: xy_r <= (state_r == ST_RAT) ?
                               ((rat_num != 61'd0) ? 32'h80000000 : 32'd0) : rat_val;
          endcase
          comp_r <= (comp_r == 2'd2) ? 2'd0 : comp_r + 2'd1;
        end
      end
      ST_MATRIX: begin
        c0x_r <= ONE_Q30 - $signed({1'b0, xx_r});
        c0y_r <= -xys;
        c0z_r <= -33'(ux_r);
        c1x_r <= -xys;
        c1y_r <= ONE_Q30 - $signed({1'b0, yy_r});
        c1z_r <= -33'(uy_r);
      end
      ST_PH_DIV: begin
        q0_r    <= div_quo[32:0];
        r0_r    <= div_rem[6:0];
        phase_r <= '0;
        prem_r  <= '0;
        idx_r   <= '0;
      end
      ST_P_COR: begin
        case (phase_r[31:30])
          2'd0: begin cs_r <= cor_x;  sn_r <= cor_y;  end
          2'd1: begin cs_r <= -cor_y; sn_r <= cor_x;  end
          2'd2: begin cs_r <= -cor_x; sn_r <= -cor_y; end
          default: begin cs_r <= cor_y; sn_r <= -cor_x; end
        endcase
      end
      ST_P_MY: px_r <= px_rnd[33:0];
      ST_P_M0: py_r <= px_rnd[33:0];
      ST_P_M1: acc_r <= mul_p_r;
      ST_P_M2: ox_r <= fin(cen_x_r, acc_r + mul_p_r);
      ST_P_M3: acc_r <= mul_p_r;
      ST_P_M4: oy_r <= fin(cen_y_r, acc_r + mul_p_r);
      ST_P_M5: acc_r <= mul_p_r;
      ST_P_ZS: oz_r <= fin(cen_z_r, acc_r + mul_p_r);
      ST_P_EMIT: begin
        if (emit_ok) begin
          idx_r <= idx_r + 7'd1;
          if (rr >= {1'b0, n_r}) begin
            prem_r  <= 7'(rr - {1'b0, n_r});
            phase_r <= phase_r + q0_r + 33'd1;
          end else begin
            prem_r  <= rr[6:0];
            phase_r <= phase_r + q0_r;
          end
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_P_EMIT && emit_ok) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_P_EMIT && emit_ok) begin
      out_data_r <= {oz_r, oy_r, ox_r};
      out_last_r <= (idx_r == n_r - 7'd1);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
